// ----- rtl/core/periodic_timer_slot_table_assert.svh -----
// Assertion macros used by the periodic timer slot table sequencer.
`ifndef PERIODIC_TIMER_SLOT_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_SLOT_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every clock edge outside reset.
`define PTST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ptst: assertion failed");

// Checks that a condition never occurs outside reset.
`define PTST_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ptst: forbidden condition seen");

`else

`define PTST_ASSERT(label, clk, rst, prop)
`define PTST_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- rtl/core/ptst_pkg.sv -----
// Package with the constants, types and helper functions of the timer slot table.
`default_nettype none

package ptst_pkg;

   localparam int SLOTS       = 16;
   localparam int TICK_BITS   = 32;

   localparam int IDX_BITS    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS    = $clog2(SLOTS + 1);

   localparam int NOW_BITS    = 32;
   localparam int PERIOD_BITS = 31;
   localparam int REM_BITS    = 32;
   localparam int MASK_BITS   = 16;
   localparam int INDEX_BITS  = 4;

   localparam int MASK_EXT    = (SLOTS > MASK_BITS) ? SLOTS : MASK_BITS;
   localparam int INDEX_EXT   = (IDX_BITS > INDEX_BITS) ? IDX_BITS : INDEX_BITS;

   localparam logic MODE_ADD  = 1'b1;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] period;
      logic [REM_BITS-1:0]    remaining;
   } slot_type;

   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      slot_type            data;
   } mem_wr_type;

   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic [MASK_BITS-1:0]  fired_mask;
      logic [INDEX_BITS-1:0] slot_index;
      logic                  table_full;
   } res_type;

   // Slots beyond the width of the result mask are dropped.
   function automatic logic [MASK_BITS-1:0] fold_mask(input logic [SLOTS-1:0] mask);
      logic [MASK_EXT-1:0] wide;
      wide = MASK_EXT'(mask);
      return wide[MASK_BITS-1:0];
   endfunction

   // The reported slot index keeps only its low bits.
   function automatic logic [INDEX_BITS-1:0] fold_index(input logic [IDX_BITS-1:0] idx);
      logic [INDEX_EXT-1:0] wide;
      wide = INDEX_EXT'(idx);
      return wide[INDEX_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ptst_req_if.sv -----
// Request channel interface: valid, ready and the request word.
`default_nettype none

interface ptst_req_if;
   import ptst_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [NOW_BITS-1:0]    now_tick;
   logic [PERIOD_BITS-1:0] period;

   modport source (output valid, output mode, output now_tick, output period, input ready);
   modport sink   (input valid, input mode, input now_tick, input period, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ptst_rsp_if.sv -----
// Response channel interface: valid, ready and the response word.
`default_nettype none

interface ptst_rsp_if;
   import ptst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MASK_BITS-1:0]  fired_mask;
   logic [INDEX_BITS-1:0] slot_index;
   logic                  table_full;

   modport source (output valid, output fired_mask, output slot_index, output table_full,
                   input ready);
   modport sink   (input valid, input fired_mask, input slot_index, input table_full,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ptst_slot_mem.sv -----
// Slot memory holding each timer's interval and remaining count, registered read.
`default_nettype none

module ptst_slot_mem (
   input  logic                 clock,
   input  ptst_pkg::mem_wr_type wr,
   input  ptst_pkg::mem_rd_type rd,
   output ptst_pkg::slot_type   rd_data
);
   import ptst_pkg::*;

   slot_type mem_ff [SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ptst_ctrl.sv -----
// Sequencer for add and tick words: slot allocation and the read-modify-write sweep.
`default_nettype none

`include "periodic_timer_slot_table_assert.svh"

module ptst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   ptst_req_if.sink             req_ch,
   output ptst_pkg::mem_rd_type mem_rd,
   output ptst_pkg::mem_wr_type mem_wr,
   input  ptst_pkg::slot_type   rd_data,
   output ptst_pkg::res_type    res,
   output logic                 res_valid,
   input  logic                 res_take
);
   import ptst_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [SLOTS-1:0]       slot_valid_ff, slot_valid_in;
   logic [TICK_BITS-1:0]   last_ff, last_in;
   logic [REM_BITS-1:0]    d_ff, d_in;
   logic [SLOTS-1:0]       fired_ff, fired_in;
   res_type                res_ff, res_in;

   logic                   s1_vld_ff, s1_vld_in;
   logic [IDX_BITS-1:0]    s1_addr_ff, s1_addr_in;
   logic                   s2_vld_ff, s2_vld_in;
   logic [IDX_BITS-1:0]    s2_addr_ff, s2_addr_in;
   logic [REM_BITS-1:0]    s2_rem_ff, s2_rem_in;
   logic [PERIOD_BITS-1:0] s2_period_ff, s2_period_in;

   logic                   accept;
   logic                   free_found;
   logic [IDX_BITS-1:0]    free_idx;
   logic [TICK_BITS-1:0]   now_t;
   logic [TICK_BITS-1:0]   diff;
   logic                   expired;
   logic [REM_BITS-1:0]    sum;
   logic [REM_BITS-1:0]    reload;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign res          = res_ff;
   assign res_valid    = (state_ff == ST_DONE);

   assign now_t = TICK_BITS'(req_ch.now_tick);
   assign diff  = now_t - last_ff;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_BITS'(i);
         end
      end
   end

   // Second sweep stage: an expired count is reloaded by its interval.
   assign expired = (s2_rem_ff == '0) || s2_rem_ff[REM_BITS-1];
   assign sum     = s2_rem_ff + REM_BITS'(s2_period_ff);
   assign reload  = !expired ? s2_rem_ff :
                    (sum[REM_BITS-1] ? REM_BITS'(s2_period_ff) : sum);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      slot_valid_in = slot_valid_ff;
      last_in       = last_ff;
      d_in          = d_ff;
      fired_in      = fired_ff;
      res_in        = res_ff;
      mem_rd        = '0;
      mem_wr        = '0;

      s1_vld_in     = 1'b0;
      s1_addr_in    = s1_addr_ff;
      s2_vld_in     = s1_vld_ff;
      s2_addr_in    = s1_addr_ff;
      s2_rem_in     = rd_data.remaining - d_ff;
      s2_period_in  = rd_data.period;

      if (s2_vld_ff && slot_valid_ff[s2_addr_ff]) begin
         mem_wr.en             = 1'b1;
         mem_wr.addr           = s2_addr_ff;
         mem_wr.data.period    = s2_period_ff;
         mem_wr.data.remaining = reload;
         if (expired) begin
            fired_in[s2_addr_ff] = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.mode == MODE_ADD) begin
                  res_in = '0;
                  if (free_found) begin
                     slot_valid_in[free_idx] = 1'b1;
                     mem_wr.en               = 1'b1;
                     mem_wr.addr             = free_idx;
                     mem_wr.data.period      = req_ch.period;
                     mem_wr.data.remaining   = REM_BITS'(req_ch.period);
                     res_in.slot_index       = fold_index(free_idx);
                  end else begin
                     res_in.table_full = 1'b1;
                  end
                  state_in = ST_DONE;
               end else begin
                  d_in     = REM_BITS'(diff);
                  last_in  = now_t;
                  fired_in = '0;
                  cnt_in   = '0;
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            if (cnt_ff < CNT_BITS'(SLOTS)) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = cnt_ff[IDX_BITS-1:0];
               s1_vld_in   = 1'b1;
               s1_addr_in  = cnt_ff[IDX_BITS-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               res_in            = '0;
               res_in.fired_mask = fold_mask(fired_ff);
               state_in          = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         slot_valid_ff <= '0;
         last_ff       <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         slot_valid_ff <= slot_valid_in;
         last_ff       <= last_in;
         s1_vld_ff     <= s1_vld_in;
         s2_vld_ff     <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff         <= d_in;
      fired_ff     <= fired_in;
      res_ff       <= res_in;
      s1_addr_ff   <= s1_addr_in;
      s2_addr_ff   <= s2_addr_in;
      s2_rem_ff    <= s2_rem_in;
      s2_period_ff <= s2_period_in;
   end

   `PTST_ASSERT(a_wr_only_when_busy, clock, reset, mem_wr.en |-> (state_ff == ST_SWEEP || (accept && req_ch.mode == MODE_ADD)))
   `PTST_NEVER(a_no_rw_same_slot, clock, reset, mem_wr.en && mem_rd.en && mem_wr.addr == mem_rd.addr)
   `PTST_ASSERT(a_add_claims_slot, clock, reset, (accept && req_ch.mode == MODE_ADD && free_found) |=> slot_valid_ff[$past(free_idx)])
   `PTST_NEVER(a_fired_only_valid, clock, reset, state_ff == ST_SWEEP && (fired_ff & ~slot_valid_ff) != '0)

endmodule

`default_nettype wire

// ----- rtl/core/periodic_timer_slot_table.sv -----
// Top level of the periodic timer slot table: sequencer, slot memory and response register.
//
// Usage:
// The req_ch channel takes one word at a time. A word with mode 1 adds a periodic
// timer in the lowest free slot and answers with its slot index, or with table_full
// when every slot is taken. A word with mode 0 carries the current tick count; the
// elapsed ticks are subtracted from every active timer and the response carries the
// mask of timers that expired, each of which is reloaded with its interval.
// Every request word gives exactly one response word on rsp_ch.
// An add is registered in the sequencer's result register, then in the response register.
// A tick walks the slot memory one slot per cycle through a two-stage read-modify-write
// pipeline, and req_ch takes no new request while the sweep runs.
// A new request is taken once the previous response has moved into the response
// register, so a stalled receiver leaves at most two finished responses in the block,
// one in the response register and one waiting in the sequencer, before req_ch stalls.
// While rsp_ch.ready is low the response word is held unchanged.
// Reset clears all slots to free and the last tick count to zero; no clearing pass
// over the memory is needed.
`default_nettype none

module periodic_timer_slot_table (
   input  logic       clock,
   input  logic       reset,
   ptst_req_if.sink   req_ch,
   ptst_rsp_if.source rsp_ch
);
   import ptst_pkg::*;

   mem_rd_type mem_rd;
   mem_wr_type mem_wr;
   slot_type   rd_data;
   res_type    res;
   logic       res_valid;
   logic       res_take;

   logic       out_vld_ff, out_vld_in;
   res_type    out_ff, out_in;

   ptst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .mem_rd    (mem_rd),
      .mem_wr    (mem_wr),
      .rd_data   (rd_data),
      .res       (res),
      .res_valid (res_valid),
      .res_take  (res_take)
   );

   ptst_slot_mem u_slot_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (rd_data)
   );

   assign res_take = res_valid && (!out_vld_ff || rsp_ch.ready);

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (out_vld_ff && rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end
      if (res_take) begin
         out_vld_in = 1'b1;
         out_in     = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.fired_mask = out_ff.fired_mask;
   assign rsp_ch.slot_index = out_ff.slot_index;
   assign rsp_ch.table_full = out_ff.table_full;

endmodule

`default_nettype wire
